// ===== rtl/core/mux_frame_deframer_assert.svh =====
// Assertion macros for the frame deframer front end (mfd_front).
// Needs nothing but the file that includes it.
`ifndef MUX_FRAME_DEFRAMER_ASSERT_SVH
`define MUX_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MFD_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("mfd assertion failed");

// Next-cycle implication, checked outside reset.
`define MFD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("mfd assertion failed");

`endif

// ===== rtl/core/mfd_pkg.sv =====
// Types and constants of the frame deframer.
// Used by every module of the block; depends on nothing.
package mfd_pkg;

   localparam int unsigned HDR_BYTES      = 14;
   localparam int unsigned HDR_COUNT_W    = 4;
   localparam int unsigned QUEUE_DEPTH    = 4;
   localparam int unsigned CSR_INDEX_W    = 1;
   localparam int unsigned CSR_DATA_W     = 8;

   localparam logic [HDR_COUNT_W-1:0] HDR_MAGIC_POS  = HDR_COUNT_W'(0);
   localparam logic [HDR_COUNT_W-1:0] HDR_TYPE_POS   = HDR_COUNT_W'(1);
   localparam logic [HDR_COUNT_W-1:0] HDR_LENGTH_POS = HDR_COUNT_W'(10);
   localparam logic [HDR_COUNT_W-1:0] HDR_LAST_POS   = HDR_COUNT_W'(HDR_BYTES - 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_MAGIC_VALUE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TYPE_MASK   = CSR_INDEX_W'(1);

   localparam logic [7:0] MAGIC_RESET     = 8'h00;
   localparam logic [7:0] TYPE_MASK_RESET = 8'hFF;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_HALTED  = 3'b100
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  frame_type;
      logic [63:0] flow_id;
      logic [31:0] frame_length;
      logic [7:0]  payload_byte;
      logic        frame_last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } push_type;

endpackage

// ===== rtl/core/mfd_front.sv =====
// Front end of the frame deframer: configuration registers, header collection
// and classification of accepted bytes into result transactions. Uses mfd_pkg.
`include "mux_frame_deframer_assert.svh"

module mfd_front
   import mfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output push_type               push
);

   phase_type              phase_ff, phase_in;
   logic [HDR_COUNT_W-1:0] hdr_count_ff, hdr_count_in;
   logic [7:0]             magic_seen_ff, magic_seen_in;
   logic [7:0]             type_ff, type_in;
   logic [63:0]            stream_ff, stream_in;
   logic [31:0]            length_ff, length_in;
   logic [31:0]            remaining_ff, remaining_in;
   logic [7:0]             magic_value_ff, type_mask_ff;
   logic [31:0]            length_full;

   assign length_full = {length_ff[23:0], data_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_value_ff <= MAGIC_RESET;
         type_mask_ff   <= TYPE_MASK_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAGIC_VALUE: magic_value_ff <= csr_wdata;
            CSR_TYPE_MASK:   type_mask_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      hdr_count_in  = hdr_count_ff;
      magic_seen_in = magic_seen_ff;
      type_in       = type_ff;
      stream_in     = stream_ff;
      length_in     = length_ff;
      remaining_in  = remaining_ff;
      push          = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               push.valid              = 1'b1;
               push.data.kind          = KIND_PAYLOAD;
               push.data.frame_type    = type_ff;
               push.data.flow_id       = stream_ff;
               push.data.frame_length  = length_ff;
               push.data.payload_byte  = data_byte;
               push.data.frame_last    = (remaining_ff == 32'd1);
               remaining_in            = remaining_ff - 32'd1;
               if (remaining_ff == 32'd1) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               priority if (hdr_count_ff == HDR_MAGIC_POS) begin
                  magic_seen_in = data_byte;
               end else if (hdr_count_ff == HDR_TYPE_POS) begin
                  type_in = data_byte;
               end else if (hdr_count_ff < HDR_LENGTH_POS) begin
                  stream_in = {stream_ff[55:0], data_byte};
               end else begin
                  length_in = length_full;
               end
               if (hdr_count_ff == HDR_LAST_POS) begin
                  hdr_count_in = '0;
                  push.valid   = 1'b1;
                  if (magic_seen_ff != magic_value_ff) begin
                     push.data.kind = KIND_ERROR;
                     phase_in       = PH_HALTED;
                  end else begin
                     type_in                = type_ff & type_mask_ff;
                     remaining_in           = length_full;
                     push.data.kind         = KIND_HEADER;
                     push.data.frame_type   = type_ff & type_mask_ff;
                     push.data.flow_id      = stream_ff;
                     push.data.frame_length = length_full;
                     push.data.frame_last   = (length_full == 32'd0);
                     phase_in = (length_full != 32'd0) ? PH_PAYLOAD : PH_HEADER;
                  end
               end else begin
                  hdr_count_in = hdr_count_ff + HDR_COUNT_W'(1);
               end
            end
            PH_HALTED: begin
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_count_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_count_ff <= hdr_count_in;
      end
   end

   always_ff @(posedge clock) begin
      magic_seen_ff <= magic_seen_in;
      type_ff       <= type_in;
      stream_ff     <= stream_in;
      length_ff     <= length_in;
      remaining_ff  <= remaining_in;
   end

   `MFD_ASSERT_NEXT(a_halt_sticks, clock, reset, phase_ff == PH_HALTED, phase_ff == PH_HALTED)
   `MFD_ASSERT_NEXT(a_error_halts, clock, reset,
      push.valid && (push.data.kind == KIND_ERROR), phase_ff == PH_HALTED)
   `MFD_ASSERT_NOW(a_error_at_header_end, clock, reset,
      push.valid && (push.data.kind == KIND_ERROR), hdr_count_ff == HDR_LAST_POS)
   `MFD_ASSERT_NOW(a_payload_nonzero, clock, reset,
      phase_ff == PH_PAYLOAD, (remaining_ff != 32'd0) && (hdr_count_ff == '0))

endmodule

// ===== rtl/core/mfd_queue.sv =====
// Short result queue between the front end and the output stage.
// Uses mfd_pkg for the result transaction type.
module mfd_queue
   import mfd_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output rsp_type  head_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   rsp_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (push.valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push.valid) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

// ===== rtl/core/mfd_back.sv =====
// Output stage of the frame deframer: drains the queue into the result register.
// Uses mfd_pkg for the result transaction type.
module mfd_back
   import mfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  rsp_type head_data,
   output logic    pop,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = head_data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/core/mux_frame_deframer.sv =====
// Length-prefixed frame deframer, one received byte per request transaction.
// The req channel carries bytes; the rsp channel carries header, payload and
// error transactions. Both use valid and stall; a transaction moves at a rising
// edge with valid high and stall low.
// Each frame is a 14-byte header (magic, type, 64-bit stream id, 32-bit
// length, big-endian) and then the payload. The fourteenth header byte gives a
// header transaction, or an error transaction if the magic byte is wrong, after
// which every byte is dropped until reset. Each payload byte gives one
// transaction; the last one of a frame has frame_last set.
// Throughput is one byte per cycle while req_stall is low. Each result goes
// through the queue entry and then the output register to rsp; the queue
// holds QUEUE_DEPTH results ahead of the register; req_stall rises only when
// that queue is full, so a stalled receiver backs up into the sender after
// QUEUE_DEPTH + 1 results. The csr port writes magic_value (index 0) and
// type_mask (index 1). Reset returns to header collection with magic 0 and
// mask 0xFF, and empties the queue and the output register.
// Depends on mfd_pkg, mfd_front, mfd_queue and mfd_back.
module mux_frame_deframer
   import mfd_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_frame_type,
   output logic [63:0]            rsp_flow_id,
   output logic [31:0]            rsp_frame_length,
   output logic [7:0]             rsp_payload_byte,
   output logic                   rsp_frame_last,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   push_type push;
   logic     queue_full;
   logic     head_valid;
   rsp_type  head_data;
   logic     pop;
   rsp_type  rsp_data;

   assign req_stall = queue_full;

   mfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_valid && !req_stall),
      .data_byte (req_data_byte),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push)
   );

   mfd_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   mfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_frame_type   = rsp_data.frame_type;
   assign rsp_flow_id      = rsp_data.flow_id;
   assign rsp_frame_length = rsp_data.frame_length;
   assign rsp_payload_byte = rsp_data.payload_byte;
   assign rsp_frame_last   = rsp_data.frame_last;

endmodule
